@@ hdl/hlcfp_pkg.sv @@
// Shared types and constants for the header/length/checksum frame parser.
package hlcfp_pkg;

	localparam int STORE_DEPTH_DEF = 64;

	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 24;

	localparam logic [7:0] SYNC_FIRST  = 8'hFE;
	localparam logic [7:0] SYNC_SECOND = 8'hEF;

	localparam logic [1:0] ACT_BYTE    = 2'd0;
	localparam logic [1:0] ACT_READ    = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_READ,
		CMD_RELEASE,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] rx_byte;
		logic [5:0] read_index;
	} cmd_t;

	// lowest bit first: byte_accepted, frame_valid, checksum_error,
	// frame_length, read_data
	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] frame_length;
		logic       checksum_error;
		logic       frame_valid;
		logic       byte_accepted;
	} result_t;

endpackage

@@ hdl/header_length_checksum_frame_parser.sv @@
// Top level of the header/length/checksum frame parser.
//
// Use: requests enter on the s_axis channel, one per handshake. tuser carries
// the action (byte, read, release); tdata carries the received byte and the
// read index. Every request yields exactly one result on m_axis, in order.
// Once a request leaves the two-entry front queue: a refused byte, a release,
// an unused action or an out-of-range read goes straight to the result; a
// parsed byte is written to the store; a byte that completes a sync header
// rewrites slots 0..2; a read does a registered read of the frame store RAM;
// a byte that completes a frame starts the checksum walk, which reads the
// store one byte per cycle over slots 0..len + 3.
// The parse sequencer takes a new request only when it has finished the last
// one. The front queue keeps taking requests while the back end works or the
// result waits.
// Reset: state is cleared at once; a per-slot valid bit makes every slot read
// as zero until written, so there is no clearing pass and requests are taken
// right after reset. If m_axis stalls, the result is held, the back end stops
// before its next request, and s_axis backs up once the queue is full.
module header_length_checksum_frame_parser #(
	parameter int STORE_DEPTH = hlcfp_pkg::STORE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [7:0] rx_byte, [13:8] read_index, [15:14] zero
	input  logic [hlcfp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] action
	input  logic [hlcfp_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] byte_accepted, [1] frame_valid, [2] checksum_error,
	// [10:3] frame_length, [18:11] read_data, [23:19] zero
	output logic [hlcfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import hlcfp_pkg::*;

	// decoded requests between the front queue and the back end
	cmd_t q_item;
	logic q_valid;
	logic q_pop;

	// front: accept, decode the action, buffer up to two requests
	hlcfp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_item       (q_item)
	);

	// back: store, sync/length tracking, checksum walk, result register
	hlcfp_back #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

@@ hdl/hlcfp_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
module hlcfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/hlcfp_front.sv @@
// Front end: accepts requests, classifies the action and queues them.
module hlcfp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [hlcfp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic [hlcfp_pkg::IN_TUSER_W-1:0] s_axis_tuser,
	output logic                              q_valid,
	input  logic                              q_pop,
	output hlcfp_pkg::cmd_t                   q_item
);

	import hlcfp_pkg::*;

	localparam int QD = 2;

	cmd_t       slot_q [QD];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cmd_in;
	logic       push;
	logic       pop;

	always_comb begin
		cmd_in.rx_byte    = s_axis_tdata[7:0];
		cmd_in.read_index = s_axis_tdata[13:8];
		case (s_axis_tuser)
			ACT_BYTE:    cmd_in.kind = CMD_BYTE;
			ACT_READ:    cmd_in.kind = CMD_READ;
			ACT_RELEASE: cmd_in.kind = CMD_RELEASE;
			default:     cmd_in.kind = CMD_NOP;
		endcase
	end

	assign s_axis_tready = (cnt_q != 2'(QD));
	assign q_valid       = (cnt_q != 2'd0);
	assign q_item        = slot_q[rd_ptr_q];
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

@@ hdl/hlcfp_back.sv @@
// Back end: frame store, parse sequencer, checksum walk and result register.
module hlcfp_back #(
	parameter int STORE_DEPTH = hlcfp_pkg::STORE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  hlcfp_pkg::cmd_t                    q_item,
	output logic                               q_pop,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [hlcfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import hlcfp_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [AW-1:0] LAST_POS = AW'(STORE_DEPTH - 1);
	localparam logic [8:0]    DEPTH_9  = 9'(STORE_DEPTH);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_WR    = 10'b0000000010,
		ST_H0    = 10'b0000000100,
		ST_H1    = 10'b0000001000,
		ST_H2    = 10'b0000010000,
		ST_RD    = 10'b0000100000,
		ST_RDW   = 10'b0001000000,
		ST_WALK  = 10'b0010000000,
		ST_CHECK = 10'b0100000000,
		ST_FIN   = 10'b1000000000
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [AW-1:0]    pos_q;
	logic             saw_q;
	logic             in_frame_q;
	logic             frame_ready_q;
	logic [7:0]       len_q;
	logic [STORE_DEPTH-1:0] vld_q;
	logic             rd_vld_s1;
	logic [AW-1:0]    k_q;
	logic [7:0]       sum_q;
	logic             acc_q;
	logic             err_q;
	logic [7:0]       rdata_q;
	logic             out_v_q;
	result_t          out_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [7:0]       wdata;
	logic             re;
	logic [AW-1:0]    raddr;
	logic [7:0]       ram_rdata;
	logic [7:0]       rdval;
	logic [7:0]       len_new;
	logic             done_cond;
	logic             walk_last;
	logic             sync_pair;
	logic [AW-1:0]    pos_inc;
	logic [8:0]       ridx_cur;
	logic [8:0]       ridx_new;
	logic             out_free;

	hlcfp_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// never-written entries read as the cleared value
	assign rdval     = rd_vld_s1 ? ram_rdata : 8'd0;
	assign len_new   = (pos_q == AW'(2)) ? cmd_q.rx_byte : len_q;
	assign done_cond = in_frame_q && (9'(pos_q) > (9'(len_new) + 9'd2));
	assign walk_last = (9'(k_q) == (9'(len_q) + 9'd3));
	assign sync_pair = (cmd_q.rx_byte == SYNC_SECOND) && saw_q;
	assign pos_inc   = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
	assign ridx_cur  = 9'(cmd_q.read_index);
	assign ridx_new  = 9'(q_item.read_index);
	assign out_free  = !out_v_q || m_axis_tready;
	assign q_pop     = (state_q == ST_IDLE) && q_valid && out_free;

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_q);

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = cmd_q.rx_byte;
		re    = 1'b0;
		raddr = k_q;
		case (state_q)
			ST_WR: begin
				we = 1'b1;
			end
			ST_H0: begin
				we    = 1'b1;
				waddr = AW'(0);
				wdata = SYNC_FIRST;
			end
			ST_H1: begin
				we    = 1'b1;
				waddr = AW'(1);
				wdata = SYNC_SECOND;
			end
			ST_H2: begin
				we    = 1'b1;
				waddr = AW'(2);
				wdata = 8'(STORE_DEPTH);
			end
			ST_RD: begin
				re    = 1'b1;
				raddr = ridx_cur[AW-1:0];
			end
			ST_WALK: begin
				re = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pos_q         <= '0;
			saw_q         <= 1'b0;
			in_frame_q    <= 1'b0;
			frame_ready_q <= 1'b0;
			len_q         <= 8'd0;
			vld_q         <= '0;
			rd_vld_s1     <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			// result register is always empty when a request finishes
			if (state_q == ST_FIN) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
				if (waddr == AW'(2)) begin
					len_q <= wdata;
				end
			end
			if (re) begin
				rd_vld_s1 <= vld_q[raddr];
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_item.kind)
							CMD_BYTE:    state_q <= frame_ready_q ? ST_FIN : ST_WR;
							CMD_READ:    state_q <= (ridx_new < DEPTH_9) ? ST_RD : ST_FIN;
							CMD_RELEASE: begin
								frame_ready_q <= 1'b0;
								state_q       <= ST_FIN;
							end
							default:     state_q <= ST_FIN;
						endcase
					end
				end
				ST_WR: begin
					if (sync_pair) begin
						// header restart: rewrite slots 0..2, resume at slot 2
						saw_q      <= 1'b0;
						in_frame_q <= 1'b1;
						pos_q      <= AW'(2);
						state_q    <= ST_H0;
					end else begin
						pos_q <= pos_inc;
						saw_q <= !done_cond && (cmd_q.rx_byte == SYNC_FIRST);
						if (done_cond) begin
							in_frame_q <= 1'b0;
							state_q    <= ST_WALK;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_H0:    state_q <= ST_H1;
				ST_H1:    state_q <= ST_H2;
				ST_H2:    state_q <= ST_FIN;
				ST_RD:    state_q <= ST_RDW;
				ST_RDW:   state_q <= ST_FIN;
				ST_WALK: begin
					if (walk_last) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (sum_q == rdval) begin
						frame_ready_q <= 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					cmd_q   <= q_item;
					acc_q   <= 1'b0;
					err_q   <= 1'b0;
					rdata_q <= 8'd0;
				end
			end
			ST_WR: begin
				acc_q <= 1'b1;
				k_q   <= '0;
				sum_q <= 8'd0;
			end
			ST_RDW: begin
				rdata_q <= rdval;
			end
			ST_WALK: begin
				// the registered read returns the data of the previous address
				if (k_q != '0) begin
					sum_q <= sum_q + rdval;
				end
				k_q <= k_q + 1'b1;
			end
			ST_CHECK: begin
				err_q <= (sum_q != rdval);
			end
			ST_FIN: begin
				out_q.byte_accepted  <= acc_q;
				out_q.frame_valid    <= frame_ready_q;
				out_q.checksum_error <= err_q;
				out_q.frame_length   <= len_q;
				out_q.read_data      <= rdata_q;
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	a_ready_not_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_frame_q && frame_ready_q))
		else $error("frame ready while a frame is still being parsed");

	a_pos_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		9'(pos_q) < DEPTH_9)
		else $error("write position beyond store");

	a_fin_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> !out_v_q)
		else $error("result register overwritten");

	a_err_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.checksum_error) |-> (out_q.byte_accepted && !out_q.frame_valid))
		else $error("checksum error on a refused byte or a valid frame");

endmodule
